// ===== hw/rtl/nam_pkg.sv =====
// ----------------------------------------------------------------------------
// nam_pkg: shared definitions of the nibble allocation map
// Field widths, map entry codes, command and status codes, and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package nam_pkg;

  // Field widths of the request and response items.
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned LENGTH_W   = 11;
  localparam int unsigned OWNER_W    = 4;
  localparam int unsigned ENTRY_W    = 4;
  localparam int unsigned STATUS_W   = 2;

  // One bit wider than an address, so that the size of the address space fits.
  localparam int unsigned SPACE_W    = ADDR_W + 1;

  // Default map depth.
  localparam int unsigned MAX_ENTRIES_DEF = 1024;

  // Register port.
  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned REG_SEL_BIT = 2;
  localparam logic [LENGTH_W-1:0] USE_LENGTH_RST = LENGTH_W'(1024);
  localparam logic [ADDR_W-1:0]   USE_BASE_RST   = '0;

  // Map entry codes.
  localparam logic [ENTRY_W-1:0] ENTRY_FREE = 4'h0;
  localparam logic [ENTRY_W-1:0] ENTRY_CONT = 4'hF;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLAIM,
    CMD_FREE,
    CMD_QUERY,
    CMD_FREE_ALL
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_OUTSIDE,
    ST_OWNER,
    ST_FREE
  } status_e;

  typedef enum logic [0:0] {
    REG_USE_BASE,
    REG_USE_LENGTH
  } reg_idx_e;

  // Walk pointer operations.
  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_OFF,
    PTR_HEAD,
    PTR_INC,
    PTR_DEC
  } ptr_op_e;

  // Remaining count operations.
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_SIZE,
    CNT_LENGTH,
    CNT_DEC
  } cnt_op_e;

  // Write data select.
  typedef enum logic [0:0] {
    WSEL_ZERO,
    WSEL_CLAIM
  } wsel_e;

  // Commands from the controller to the datapath, valid for one cycle.
  typedef struct packed {
    logic    load;
    ptr_op_e ptr_op;
    cnt_op_e cnt_op;
    logic    set_entry;
    logic    set_head;
    logic    set_head_next;
    logic    size_one;
    logic    size_inc;
    logic    set_status;
    status_e status;
    logic    wr;
    wsel_e   wsel;
    logic    fa_step;
  } dp_cmd_t;

  // Conditions reported by the datapath to the controller.
  typedef struct packed {
    cmd_e cmd;
    logic in_area;
    logic owner_bad;
    logic owner_mismatch;
    logic claim_over;
    logic length_zero;
    logic size_zero;
    logic rd_zero;
    logic rd_cont;
    logic ptr_zero;
    logic ptr_end;
    logic cnt_last;
    logic clr_done;
  } dp_stat_t;

endpackage

// ===== hw/rtl/nam_if.sv =====
// ----------------------------------------------------------------------------
// nam_if: request and response channels of the nibble allocation map
// Valid/ready channels; an item moves at a clock edge with both high.
// ----------------------------------------------------------------------------

// Request channel: one map command.
interface nam_req_if;
  logic                          valid;
  logic                          ready;
  logic [nam_pkg::CMD_W-1:0]     cmd;
  logic [nam_pkg::ADDR_W-1:0]    address;
  logic [nam_pkg::LENGTH_W-1:0]  length;
  logic [nam_pkg::OWNER_W-1:0]   owner_id;

  modport source (output valid, cmd, address, length, owner_id, input ready);
  modport sink   (input valid, cmd, address, length, owner_id, output ready);
endinterface

// Response channel: one result per request.
interface nam_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [nam_pkg::STATUS_W-1:0]  status;
  logic [nam_pkg::ENTRY_W-1:0]   entry_value;
  logic [nam_pkg::ADDR_W-1:0]    chunk_start;
  logic [nam_pkg::LENGTH_W-1:0]  chunk_size;
  logic [nam_pkg::ENTRY_W-1:0]   chunk_owner;

  modport source (output valid, status, entry_value, chunk_start, chunk_size, chunk_owner,
                  input ready);
  modport sink   (input valid, status, entry_value, chunk_start, chunk_size, chunk_owner,
                  output ready);
endinterface

// ===== hw/rtl/nam_ram.sv =====
// ----------------------------------------------------------------------------
// nam_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nam_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/nam_dp.sv =====
// ----------------------------------------------------------------------------
// nam_dp: datapath of the nibble allocation map
// Holds the request, the walk pointer and count, and the result fields, and
// drives the map RAM ports under commands from the controller.
// ----------------------------------------------------------------------------
module nam_dp #(
  parameter int unsigned MAX_ENTRIES = nam_pkg::MAX_ENTRIES_DEF,
  localparam int unsigned AW = $clog2(MAX_ENTRIES),
  localparam int unsigned PW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nam_pkg::dp_cmd_t              cmd_i,
  output nam_pkg::dp_stat_t             stat_o,
  // Request fields.
  input  logic [nam_pkg::CMD_W-1:0]     req_cmd_i,
  input  logic [nam_pkg::ADDR_W-1:0]    req_address_i,
  input  logic [nam_pkg::LENGTH_W-1:0]  req_length_i,
  input  logic [nam_pkg::OWNER_W-1:0]   req_owner_id_i,
  // Configuration.
  input  logic [nam_pkg::ADDR_W-1:0]    use_base_i,
  input  logic [nam_pkg::LENGTH_W-1:0]  use_length_i,
  // Result fields.
  output logic [nam_pkg::STATUS_W-1:0]  status_o,
  output logic [nam_pkg::ENTRY_W-1:0]   entry_value_o,
  output logic [nam_pkg::ADDR_W-1:0]    chunk_start_o,
  output logic [nam_pkg::LENGTH_W-1:0]  chunk_size_o,
  output logic [nam_pkg::ENTRY_W-1:0]   chunk_owner_o,
  // Map RAM.
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic [nam_pkg::ENTRY_W-1:0]   mem_wdata_o,
  output logic [AW-1:0]                 mem_raddr_o,
  input  logic [nam_pkg::ENTRY_W-1:0]   mem_rdata_i
);

  // Request registers.
  nam_pkg::cmd_e                  cmd_q;
  logic [nam_pkg::ADDR_W-1:0]     addr_q;
  logic [nam_pkg::LENGTH_W-1:0]   length_q;
  logic [nam_pkg::OWNER_W-1:0]    owner_q;
  logic [PW-1:0]                  len_q;

  // Walk state.
  logic [PW-1:0] ptr_q, ptr_d;
  logic [PW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] head_q;
  logic          in_run_q, in_run_d;

  // Result registers.
  nam_pkg::status_e               status_q;
  logic [nam_pkg::ENTRY_W-1:0]    entry_q;
  logic [nam_pkg::ADDR_W-1:0]     start_q;
  logic [PW-1:0]                  size_q;
  logic [nam_pkg::ENTRY_W-1:0]    hval_q;

  // Combinational helpers.
  logic [nam_pkg::SPACE_W-1:0]    room;
  logic [nam_pkg::SPACE_W-1:0]    len_full;
  logic [nam_pkg::ADDR_W-1:0]     addr_delta;
  logic [PW-1:0]                  off;
  logic [PW-1:0]                  ptr_next;
  logic [nam_pkg::ENTRY_W-1:0]    claim_val;
  logic                           fa_hit;

  // Effective area length: use_length cut to the map depth and the address space.
  always_comb begin
    room     = (nam_pkg::SPACE_W'(1) << nam_pkg::ADDR_W) - nam_pkg::SPACE_W'(use_base_i);
    len_full = nam_pkg::SPACE_W'(use_length_i);
    if (len_full > nam_pkg::SPACE_W'(MAX_ENTRIES)) begin
      len_full = nam_pkg::SPACE_W'(MAX_ENTRIES);
    end
    if (len_full > room) begin
      len_full = room;
    end
  end

  // Offset of the request address within the area.
  assign addr_delta = addr_q - use_base_i;
  assign off        = PW'(addr_delta);
  assign ptr_next   = ptr_q + PW'(1);

  // Claim writes the owner at the head and the continuation code after it.
  assign claim_val = (ptr_q == off) ? owner_q : nam_pkg::ENTRY_CONT;

  // Free-all clears an owner's head and the continuation run that follows it.
  assign fa_hit = cmd_i.fa_step &&
                  ((in_run_q && (mem_rdata_i == nam_pkg::ENTRY_CONT)) ||
                   (mem_rdata_i == owner_q));
  assign in_run_d = cmd_i.load ? 1'b0 : (cmd_i.fa_step ? fa_hit : in_run_q);

  // Status toward the controller.
  always_comb begin
    stat_o.cmd            = cmd_q;
    stat_o.in_area        = (addr_q >= use_base_i) &&
                            (nam_pkg::SPACE_W'(addr_delta) < nam_pkg::SPACE_W'(len_q));
    stat_o.owner_bad      = (owner_q == nam_pkg::ENTRY_FREE) ||
                            (owner_q == nam_pkg::ENTRY_CONT);
    stat_o.owner_mismatch = (hval_q != owner_q) || (owner_q == nam_pkg::ENTRY_CONT);
    stat_o.claim_over     = nam_pkg::SPACE_W'(length_q) > nam_pkg::SPACE_W'(len_q - off);
    stat_o.length_zero    = (length_q == '0);
    stat_o.size_zero      = (size_q == '0);
    stat_o.rd_zero        = (mem_rdata_i == nam_pkg::ENTRY_FREE);
    stat_o.rd_cont        = (mem_rdata_i == nam_pkg::ENTRY_CONT);
    stat_o.ptr_zero       = (ptr_q == '0);
    stat_o.ptr_end        = (ptr_q >= len_q);
    stat_o.cnt_last       = (cnt_q == PW'(1));
    stat_o.clr_done       = (ptr_q == PW'(MAX_ENTRIES - 1));
  end

  // Pointer update.
  always_comb begin
    unique case (cmd_i.ptr_op)
      nam_pkg::PTR_HOLD: ptr_d = ptr_q;
      nam_pkg::PTR_ZERO: ptr_d = '0;
      nam_pkg::PTR_OFF:  ptr_d = off;
      nam_pkg::PTR_HEAD: ptr_d = head_q;
      nam_pkg::PTR_INC:  ptr_d = ptr_next;
      nam_pkg::PTR_DEC:  ptr_d = ptr_q - PW'(1);
      default:           ptr_d = ptr_q;
    endcase
  end

  // Remaining count update.
  always_comb begin
    unique case (cmd_i.cnt_op)
      nam_pkg::CNT_HOLD:   cnt_d = cnt_q;
      nam_pkg::CNT_SIZE:   cnt_d = size_q;
      nam_pkg::CNT_LENGTH: cnt_d = PW'(length_q);
      nam_pkg::CNT_DEC:    cnt_d = cnt_q - PW'(1);
      default:             cnt_d = cnt_q;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      in_run_q <= 1'b0;
    end else begin
      ptr_q    <= ptr_d;
      in_run_q <= in_run_d;
    end
  end

  // Request, walk and result registers.
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    if (cmd_i.load) begin
      cmd_q    <= nam_pkg::cmd_e'(req_cmd_i);
      addr_q   <= req_address_i;
      length_q <= req_length_i;
      owner_q  <= req_owner_id_i;
      len_q    <= PW'(len_full);
      status_q <= nam_pkg::ST_OK;
      entry_q  <= nam_pkg::ENTRY_FREE;
      start_q  <= '0;
      size_q   <= '0;
      hval_q   <= nam_pkg::ENTRY_FREE;
    end
    if (cmd_i.set_entry) begin
      entry_q <= mem_rdata_i;
    end
    if (cmd_i.set_head) begin
      head_q  <= ptr_q;
      hval_q  <= mem_rdata_i;
      start_q <= use_base_i + nam_pkg::ADDR_W'(ptr_q);
    end
    if (cmd_i.set_head_next) begin
      head_q  <= ptr_next;
      hval_q  <= nam_pkg::ENTRY_FREE;
      start_q <= use_base_i + nam_pkg::ADDR_W'(ptr_next);
    end
    if (cmd_i.size_one) begin
      size_q <= PW'(1);
    end else if (cmd_i.size_inc) begin
      size_q <= size_q + PW'(1);
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
  end

  // Map RAM ports.
  assign mem_we_o    = cmd_i.wr || fa_hit;
  assign mem_waddr_o = ptr_q[AW-1:0];
  assign mem_raddr_o = ptr_q[AW-1:0];
  assign mem_wdata_o = (cmd_i.wr && (cmd_i.wsel == nam_pkg::WSEL_CLAIM)) ? claim_val
                                                                          : nam_pkg::ENTRY_FREE;

  // Result fields.
  assign status_o      = status_q;
  assign entry_value_o = entry_q;
  assign chunk_start_o = start_q;
  assign chunk_size_o  = nam_pkg::LENGTH_W'(size_q);
  assign chunk_owner_o = hval_q;

endmodule

// ===== hw/rtl/nam_ctrl.sv =====
// ----------------------------------------------------------------------------
// nam_ctrl: controller of the nibble allocation map
// Sequences the clearing pass, the entry read, the head and size walks, the
// claim check, the chunk writes and the free-all scan.
// ----------------------------------------------------------------------------
module nam_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  input  nam_pkg::dp_stat_t stat_i,
  output nam_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISP,
    S_ENT_RD,
    S_ENT_EV,
    S_HN_RD,
    S_HN_EV,
    S_HZ_RD,
    S_HZ_EV,
    S_SZ_RD,
    S_SZ_EV,
    S_CMD,
    S_CK_RD,
    S_CK_EV,
    S_WR,
    S_FA_RD,
    S_FA_EV,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   req_ready_q;
  logic   rsp_valid_q;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      // Clear the map one entry per cycle after reset.
      S_CLEAR: begin
        cmd_o.wr     = 1'b1;
        cmd_o.wsel   = nam_pkg::WSEL_ZERO;
        cmd_o.ptr_op = nam_pkg::PTR_INC;
        if (stat_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i && req_ready_q) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      // Range and owner checks that need no map read.
      S_DISP: begin
        if (stat_i.cmd == nam_pkg::CMD_FREE_ALL) begin
          if (stat_i.owner_bad) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = nam_pkg::ST_OWNER;
            state_d          = S_OUT;
          end else begin
            cmd_o.ptr_op = nam_pkg::PTR_ZERO;
            state_d      = S_FA_RD;
          end
        end else if (!stat_i.in_area) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = nam_pkg::ST_OUTSIDE;
          state_d          = S_OUT;
        end else begin
          cmd_o.ptr_op = nam_pkg::PTR_OFF;
          state_d      = S_ENT_RD;
        end
      end
      S_ENT_RD: state_d = S_ENT_EV;
      // Entry at the address; pick the head search direction.
      S_ENT_EV: begin
        cmd_o.set_entry = 1'b1;
        if (!stat_i.rd_zero) begin
          if (stat_i.rd_cont && !stat_i.ptr_zero) begin
            cmd_o.ptr_op = nam_pkg::PTR_DEC;
            state_d      = S_HN_RD;
          end else begin
            cmd_o.set_head = 1'b1;
            cmd_o.size_one = 1'b1;
            cmd_o.ptr_op   = nam_pkg::PTR_INC;
            state_d        = S_SZ_RD;
          end
        end else if (!stat_i.ptr_zero) begin
          cmd_o.ptr_op = nam_pkg::PTR_DEC;
          state_d      = S_HZ_RD;
        end else begin
          cmd_o.set_head = 1'b1;
          state_d        = S_CMD;
        end
      end
      S_HN_RD: state_d = S_HN_EV;
      // Walk back over continuation entries to the chunk head.
      S_HN_EV: begin
        if (stat_i.rd_cont && !stat_i.ptr_zero) begin
          cmd_o.ptr_op = nam_pkg::PTR_DEC;
          state_d      = S_HN_RD;
        end else begin
          cmd_o.set_head = 1'b1;
          cmd_o.size_one = 1'b1;
          cmd_o.ptr_op   = nam_pkg::PTR_INC;
          state_d        = S_SZ_RD;
        end
      end
      S_HZ_RD: state_d = S_HZ_EV;
      // Walk back over free entries to the start of the free run.
      S_HZ_EV: begin
        if (stat_i.rd_zero) begin
          if (!stat_i.ptr_zero) begin
            cmd_o.ptr_op = nam_pkg::PTR_DEC;
            state_d      = S_HZ_RD;
          end else begin
            cmd_o.set_head = 1'b1;
            state_d        = S_CMD;
          end
        end else begin
          cmd_o.set_head_next = 1'b1;
          state_d             = S_CMD;
        end
      end
      // Count continuation entries after the head, up to the area end.
      S_SZ_RD: begin
        if (stat_i.ptr_end) begin
          state_d = S_CMD;
        end else begin
          state_d = S_SZ_EV;
        end
      end
      S_SZ_EV: begin
        if (stat_i.rd_cont) begin
          cmd_o.size_inc = 1'b1;
          cmd_o.ptr_op   = nam_pkg::PTR_INC;
          state_d        = S_SZ_RD;
        end else begin
          state_d = S_CMD;
        end
      end
      // Command decision once the chunk is known.
      S_CMD: begin
        state_d = S_OUT;
        unique case (stat_i.cmd)
          nam_pkg::CMD_FREE: begin
            if (stat_i.size_zero) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = nam_pkg::ST_FREE;
            end else if (stat_i.owner_mismatch) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = nam_pkg::ST_OWNER;
            end else begin
              cmd_o.ptr_op = nam_pkg::PTR_HEAD;
              cmd_o.cnt_op = nam_pkg::CNT_SIZE;
              state_d      = S_WR;
            end
          end
          nam_pkg::CMD_CLAIM: begin
            if (stat_i.claim_over) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = nam_pkg::ST_OUTSIDE;
            end else if (stat_i.owner_bad) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = nam_pkg::ST_OWNER;
            end else if (!stat_i.length_zero) begin
              cmd_o.ptr_op = nam_pkg::PTR_OFF;
              cmd_o.cnt_op = nam_pkg::CNT_LENGTH;
              state_d      = S_CK_RD;
            end
          end
          default: state_d = S_OUT;
        endcase
      end
      S_CK_RD: state_d = S_CK_EV;
      // Every entry of a claimed range must be free.
      S_CK_EV: begin
        if (!stat_i.rd_zero) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = nam_pkg::ST_OWNER;
          state_d          = S_OUT;
        end else if (stat_i.cnt_last) begin
          cmd_o.ptr_op = nam_pkg::PTR_OFF;
          cmd_o.cnt_op = nam_pkg::CNT_LENGTH;
          state_d      = S_WR;
        end else begin
          cmd_o.ptr_op = nam_pkg::PTR_INC;
          cmd_o.cnt_op = nam_pkg::CNT_DEC;
          state_d      = S_CK_RD;
        end
      end
      // Write the chunk: owner and continuation codes for claim, free for free.
      S_WR: begin
        cmd_o.wr     = 1'b1;
        cmd_o.wsel   = (stat_i.cmd == nam_pkg::CMD_CLAIM) ? nam_pkg::WSEL_CLAIM
                                                          : nam_pkg::WSEL_ZERO;
        cmd_o.ptr_op = nam_pkg::PTR_INC;
        cmd_o.cnt_op = nam_pkg::CNT_DEC;
        if (stat_i.cnt_last) begin
          state_d = S_OUT;
        end
      end
      // Scan the whole area for the owner's chunks.
      S_FA_RD: begin
        if (stat_i.ptr_end) begin
          state_d = S_OUT;
        end else begin
          state_d = S_FA_EV;
        end
      end
      S_FA_EV: begin
        cmd_o.fa_step = 1'b1;
        cmd_o.ptr_op  = nam_pkg::PTR_INC;
        state_d       = S_FA_RD;
      end
      S_OUT: begin
        if (rsp_valid_q && rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      req_ready_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      req_ready_q <= (state_d == S_IDLE);
      rsp_valid_q <= (state_d == S_OUT);
    end
  end

  assign req_ready_o = req_ready_q;
  assign rsp_valid_o = rsp_valid_q;

endmodule

// ===== hw/rtl/nibble_allocation_map.sv =====
// ----------------------------------------------------------------------------
// nibble_allocation_map: heap allocation map with one 4-bit entry per byte
// A request reads map entries through the single registered read port of the map
// RAM and then writes the entries it changes, unless it is refused before any map
// read; free-all reads the whole area. One request is in work at a time; the result
// is held until taken. After reset the map is cleared one entry per cycle, and no
// request is taken until then.
// ----------------------------------------------------------------------------
module nibble_allocation_map #(
  parameter int unsigned MAX_ENTRIES = nam_pkg::MAX_ENTRIES_DEF,
  localparam int unsigned AW = $clog2(MAX_ENTRIES)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  nam_req_if.sink                      req_i,
  nam_rsp_if.source                    rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nam_pkg::APB_AW-1:0]   paddr,
  input  logic [nam_pkg::APB_DW-1:0]   pwdata,
  output logic [nam_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  logic [nam_pkg::ADDR_W-1:0]   use_base_q;
  logic [nam_pkg::LENGTH_W-1:0] use_length_q;
  logic                         cfg_wr;
  nam_pkg::reg_idx_e            reg_sel;

  nam_pkg::dp_cmd_t             dp_cmd;
  nam_pkg::dp_stat_t            dp_stat;

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [nam_pkg::ENTRY_W-1:0]  mem_wdata;
  logic [AW-1:0]                mem_raddr;
  logic [nam_pkg::ENTRY_W-1:0]  mem_rdata;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = nam_pkg::reg_idx_e'(paddr[nam_pkg::REG_SEL_BIT]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_base_q   <= nam_pkg::USE_BASE_RST;
      use_length_q <= nam_pkg::USE_LENGTH_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        nam_pkg::REG_USE_BASE:   use_base_q   <= pwdata[nam_pkg::ADDR_W-1:0];
        nam_pkg::REG_USE_LENGTH: use_length_q <= pwdata[nam_pkg::LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_sel)
      nam_pkg::REG_USE_BASE:   prdata = nam_pkg::APB_DW'(use_base_q);
      nam_pkg::REG_USE_LENGTH: prdata = nam_pkg::APB_DW'(use_length_q);
      default:                 prdata = '0;
    endcase
  end

  // Sequencer.
  nam_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  // Walk registers and result fields.
  nam_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .req_cmd_i      (req_i.cmd),
    .req_address_i  (req_i.address),
    .req_length_i   (req_i.length),
    .req_owner_id_i (req_i.owner_id),
    .use_base_i     (use_base_q),
    .use_length_i   (use_length_q),
    .status_o       (rsp_o.status),
    .entry_value_o  (rsp_o.entry_value),
    .chunk_start_o  (rsp_o.chunk_start),
    .chunk_size_o   (rsp_o.chunk_size),
    .chunk_owner_o  (rsp_o.chunk_owner),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  // Allocation map storage.
  nam_ram #(
    .WIDTH (nam_pkg::ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
